/* rtl/core/vtge_pkg.sv */
// Vector tile geometry encoder: shared types, command codes and word helpers.
// Depends on nothing; imported by the channel interfaces and every core module.
package vtge_pkg;

   localparam int unsigned WORD_W          = 32;
   localparam int unsigned IDX_W           = 16;
   localparam int unsigned KIND_W          = 2;
   localparam int unsigned CMD_W           = 3;
   localparam int unsigned NWORDS          = 3;
   localparam int unsigned CNT_W           = 2;
   localparam int unsigned MAX_PART_POINTS = 65535;

   // Part kinds; the unused code behaves as a line string
   localparam logic [KIND_W-1:0] KIND_POINTS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RING   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

   // Command ids
   localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LINE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd7;

   // Point item as it arrives
   typedef struct packed {
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic [KIND_W-1:0]        part_kind;
      logic [IDX_W-1:0]         part_points;
      logic                     new_feature;
      logic                     new_part;
   } req_payload_type;

   // One output word
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last_word;
   } rsp_payload_type;

   // All words caused by one point, slot 0 goes out first
   typedef struct packed {
      logic [NWORDS-1:0][WORD_W-1:0] words;
      logic [CNT_W-1:0]              count;
   } word_group_type;

   // Command integer: id in the low three bits, count above
   function automatic logic [WORD_W-1:0] cmd_word(input logic [CMD_W-1:0] id,
                                                  input logic [IDX_W-1:0] count);
      logic [WORD_W-1:0] w;
      w = {{(WORD_W - IDX_W - CMD_W){1'b0}}, count, id};
      return w;
   endfunction

   // Zigzag code of a two's complement delta
   function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] w;
      w = {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
      return w;
   endfunction

endpackage

/* rtl/core/vtge_channels_if.sv */
// Valid/ready channel interfaces for the point input and the word output.
// Depends on vtge_pkg for the payload types.
interface vtge_req_if
   import vtge_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface vtge_rsp_if
   import vtge_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/vtge_encode.sv */
// Input register, cursor and point index state, and the word generator.
// Depends on vtge_pkg; hands a group of one to three words to vtge_word_buffer.
module vtge_encode
   import vtge_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   vtge_req_if.sink        req_if,
   output word_group_type  group_out,
   output logic            group_valid,
   input  logic            group_ready
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_ff, in_in;
   logic [WORD_W-1:0] cursor_x_ff, cursor_x_in;
   logic [WORD_W-1:0] cursor_y_ff, cursor_y_in;
   logic [IDX_W-1:0]  index_ff, index_in;

   logic              move;
   logic [IDX_W-1:0]  npts;
   logic [IDX_W-1:0]  idx;
   logic [IDX_W-1:0]  sub;
   logic [IDX_W-1:0]  line_cnt;
   logic              close;
   logic [WORD_W-1:0] base_x, base_y;
   logic [WORD_W-1:0] zig_x, zig_y;

   // Input register stage
   assign move         = in_valid_ff && group_ready;
   assign req_if.ready = !in_valid_ff || group_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
         in_in       = req_if.payload;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // Part geometry for the registered point
   always_comb begin
      if (32'(in_ff.part_points) > MAX_PART_POINTS) begin
         npts = IDX_W'(MAX_PART_POINTS);
      end else begin
         npts = in_ff.part_points;
      end
      idx      = in_ff.new_part ? '0 : index_ff;
      close    = (in_ff.part_kind == KIND_RING) && (npts != '0) && (idx == npts - 1'b1);
      sub      = (in_ff.part_kind == KIND_RING) ? IDX_W'(2) : IDX_W'(1);
      line_cnt = (npts >= sub) ? npts - sub : '0;
      base_x   = in_ff.new_feature ? '0 : cursor_x_ff;
      base_y   = in_ff.new_feature ? '0 : cursor_y_ff;
      zig_x    = zigzag($unsigned(in_ff.point_x) - base_x);
      zig_y    = zigzag($unsigned(in_ff.point_y) - base_y);
   end

   // Word group: optional command, then the two deltas; a close is ClosePath alone
   always_comb begin
      group_out.words = '0;
      group_out.count = CNT_W'(2);
      if (close) begin
         group_out.words[0] = cmd_word(CMD_CLOSE, IDX_W'(1));
         group_out.count    = CNT_W'(1);
      end else if (idx == '0) begin
         group_out.words[0] = cmd_word(CMD_MOVE,
            (in_ff.part_kind == KIND_POINTS) ? npts : IDX_W'(1));
         group_out.words[1] = zig_x;
         group_out.words[2] = zig_y;
         group_out.count    = CNT_W'(3);
      end else if ((idx == IDX_W'(1)) && (in_ff.part_kind != KIND_POINTS)) begin
         group_out.words[0] = cmd_word(CMD_LINE, line_cnt);
         group_out.words[1] = zig_x;
         group_out.words[2] = zig_y;
         group_out.count    = CNT_W'(3);
      end else begin
         group_out.words[0] = zig_x;
         group_out.words[1] = zig_y;
      end
   end

   assign group_valid = in_valid_ff;

   // Cursor and index update when the group is handed on
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      index_in    = index_ff;
      if (move) begin
         cursor_x_in = close ? base_x : $unsigned(in_ff.point_x);
         cursor_y_in = close ? base_y : $unsigned(in_ff.point_y);
         index_in    = (idx != '1) ? idx + 1'b1 : idx;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         index_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         index_ff    <= index_in;
      end
   end

   // A handed-on group always carries one to three words
   a_group_count: assert property (@(posedge clock) disable iff (reset)
      group_valid |-> (group_out.count != '0))
      else $error("word group with no words");

   // A closing point carries exactly one word
   a_close_single: assert property (@(posedge clock) disable iff (reset)
      (group_valid && close) |-> (group_out.count == CNT_W'(1)))
      else $error("closing point emits more than one word");

   // A closing point leaves the cursor where it was, apart from a feature reset
   a_close_cursor: assert property (@(posedge clock) disable iff (reset)
      (move && close && !in_ff.new_feature) |=> $stable(cursor_x_ff) && $stable(cursor_y_ff))
      else $error("cursor moved on a closing point");

endmodule

/* rtl/core/vtge_word_buffer.sv */
// Output buffer: holds one word group, shifts out one word per cycle while ready.
// Depends on vtge_pkg; drives the result channel.
module vtge_word_buffer
   import vtge_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  word_group_type group_in,
   input  logic           group_valid,
   output logic           group_ready,
   vtge_rsp_if.source     rsp_if
);

   logic [NWORDS-1:0][WORD_W-1:0] words_ff, words_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          take;

   // Free when empty or the last word leaves this cycle
   assign take        = rsp_if.valid && rsp_if.ready;
   assign group_ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_if.ready);

   assign rsp_if.valid             = (cnt_ff != '0);
   assign rsp_if.payload.word      = words_ff[0];
   assign rsp_if.payload.last_word = (cnt_ff == CNT_W'(1));

   // Load a new group or shift toward slot 0
   always_comb begin
      words_in = words_ff;
      cnt_in   = cnt_ff;
      if (group_valid && group_ready) begin
         words_in = group_in.words;
         cnt_in   = group_in.count;
      end else if (take) begin
         words_in = {{WORD_W{1'b0}}, words_ff[NWORDS-1:1]};
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // A loaded group shows its full count next cycle
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      (group_valid && group_ready) |=> (cnt_ff == $past(group_in.count)))
      else $error("buffer count differs from loaded group");

   // Taking a word that is not the last drops the count by one
   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (take && (cnt_ff > CNT_W'(1))) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("buffer count skipped a word");

   // Never free while more than one word is still pending
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > CNT_W'(1)) |-> !group_ready)
      else $error("buffer free with words pending");

endmodule

/* rtl/core/vector_tile_geometry_encoder_core.sv */
// Vector tile geometry encoder, top level: point input, word output.
// Depends on vtge_pkg, vtge_channels_if, vtge_encode and vtge_word_buffer.
//
// Each accepted point yields one to three 32-bit words on the result channel:
// an optional MoveTo, LineTo or ClosePath command word followed by the zigzag
// coded x and y deltas from the cursor (a ring's closing point yields only
// ClosePath); last_word marks the final word of each point. A point waits in
// an input register until the output buffer is free, its words are then loaded
// into the buffer and leave one per cycle while the result channel is ready.
// A point has three words if it is the first point of a part or the second
// point of a line or ring, one if it is a ring's closing point, two otherwise.
// The single word port limits the rate; while the buffer drains, one further
// point waits in the input register and the input is not ready. With the
// buffer empty, an accepted point goes from the input register into the
// output buffer, whose slot 0 drives the first word on the result port.
module vector_tile_geometry_encoder_core
   import vtge_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   vtge_req_if.sink   req_if,
   vtge_rsp_if.source rsp_if
);

   word_group_type group;
   logic           group_valid;
   logic           group_ready;

   vtge_encode u_encode (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .group_out   (group),
      .group_valid (group_valid),
      .group_ready (group_ready)
   );

   vtge_word_buffer u_word_buffer (
      .clock       (clock),
      .reset       (reset),
      .group_in    (group),
      .group_valid (group_valid),
      .group_ready (group_ready),
      .rsp_if      (rsp_if)
   );

endmodule
